// ----- rtl/circle_tangent_point_top_assert.svh -----
// Assertion macros for the tangent-point block.
// Used by circle_tangent_point_top; no other dependencies.
`ifndef CIRCLE_TANGENT_POINT_TOP_ASSERT_SVH
`define CIRCLE_TANGENT_POINT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CTP_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CTP_ASSERT_RESET(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTP_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define CTP_ASSERT_RESET(label, clk, rstn, prop, msg)
`endif
`endif

// ----- rtl/ctp_pkg.sv -----
// Shared types and constants for the tangent-point pipeline.
// No dependencies.
package ctp_pkg;
    localparam int COORD_BITS   = 24;
    localparam int RADIUS_WIDTH = 23;
    localparam int RATIO_BITS   = 30;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 23'd24576;

    // Control that travels beside each pipeline slot.
    typedef struct packed {
        logic valid;
        logic in_circle;
    } ctp_ctrl_t;
endpackage

// ----- rtl/ctp_isqrt_stage.sv -----
// One restoring square-root step: two bits of radicand, one root bit.
// Depends on nothing but its parameter.
module ctp_isqrt_stage #(
    parameter int W = 64
) (
    input  logic [W-1:0]   rem_in,
    input  logic [W/2-1:0] root_in,
    input  logic [1:0]     pair_in,
    output logic [W-1:0]   rem_out,
    output logic [W/2-1:0] root_out
);
    logic [W+1:0] shifted;
    logic [W+1:0] trial;

    // Bring in the next bit pair and try the root candidate 4*root+1.
    always_comb begin
        shifted = {rem_in, pair_in};
        trial   = {{(W/2){1'b0}}, root_in, 2'b01};
        if (shifted >= trial) begin
            rem_out  = W'(shifted - trial);
            root_out = {root_in[W/2-2:0], 1'b1};
        end else begin
            rem_out  = W'(shifted);
            root_out = {root_in[W/2-2:0], 1'b0};
        end
    end
endmodule

// ----- rtl/ctp_div_stage.sv -----
// One restoring division step producing one quotient bit.
// Depends on nothing but its parameter.
module ctp_div_stage #(
    parameter int W = 64
) (
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] den,
    output logic [W-1:0] rem_out,
    output logic         q_bit
);
    logic [W:0] twice;

    // Doubled remainder minus the divisor when it fits.
    always_comb begin
        twice = {rem_in, 1'b0};
        if (twice >= {1'b0, den}) begin
            rem_out = W'(twice - {1'b0, den});
            q_bit   = 1'b1;
        end else begin
            rem_out = W'(twice);
            q_bit   = 1'b0;
        end
    end
endmodule

// ----- rtl/circle_tangent_point_top.sv -----
// Top level of the tangent-point pipeline.
// Depends on ctp_pkg, ctp_isqrt_stage, ctp_div_stage and the assertion header.
//
//  channel   | dir | tdata fields (low bit up)                       | tuser
//  s_axis    | in  | circle_x, circle_y, flange_x, flange_y          | -
//  m_axis    | out | tangent_x, tangent_y                            | inside_flag
//  cfg       | in  | radius (23 bits)                                | -
//
// One transaction per cycle while the result side does not stall. Stages: two front
// stages, one square-root stage per root bit (27), the numerator stage, one divider stage
// per quotient bit (31) and the scale, compare and output stages.
// Reset clears only valid bits and loads the radius register with its reset value.
// A stall on the result side freezes every stage at once, so s_axis_tready
// follows m_axis_tready combinationally while the last stage holds a result.
`include "circle_tangent_point_top_assert.svh"
module circle_tangent_point_top
    import ctp_pkg::*;
#(
    parameter int FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [RADIUS_WIDTH-1:0] cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // circle_x, circle_y, flange_x, flange_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tangent_x, tangent_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // inside_flag
    output logic                    m_axis_tuser
);
    localparam int CB  = COORD_BITS;
    localparam int DB  = CB + 2;            // signed offset width
    localparam int MB  = 2 * DB + 1;        // d2 width
    localparam int SQW = MB + (MB % 2);     // even radicand width
    localparam int SB  = SQW / 2;           // root width
    localparam int NB  = DB + SB + 2;       // numerator magnitude width (|N|<=d2)
    localparam int DW  = (NB > MB ? NB : MB) + 1;
    localparam int QB  = RATIO_BITS + 1;    // q <= 2^30
    localparam int OUT_PAD = ((2*CB+7)/8)*8 - 2*CB;
    // Stage counts
    localparam int NSQ = SB;
    localparam int NDV = QB;
    localparam int DEPTH = 2 + NSQ + 1 + NDV + 3;

    // Radius register, reset to 0.375 in the coordinate format.
    logic [RADIUS_WIDTH-1:0] radius_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_WIDTH'(3) << (FRAC_BITS - 3);
        end else if (cfg_we) begin
            radius_reg <= cfg_wdata;
        end
    end

    // Global advance: pipeline moves when output slot is free.
    logic adv;
    logic [DEPTH-1:0] v_reg;
    assign adv = !v_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Stage 0: centre and offsets.
    logic signed [DB-1:0] cy0_reg, cx0_reg, dx0_reg, dy0_reg;
    logic [RADIUS_WIDTH-1:0] r0_reg;
    logic signed [CB-1:0] icx, icy, ifx, ify;
    logic signed [DB-1:0] cyn;
    assign icx = s_axis_tdata[CB-1:0];
    assign icy = s_axis_tdata[2*CB-1:CB];
    assign ifx = s_axis_tdata[3*CB-1:2*CB];
    assign ify = s_axis_tdata[4*CB-1:3*CB];
    always_comb begin
        if (ify < icy) cyn = DB'(icy) + DB'(signed'({1'b0, radius_reg}));
        else           cyn = DB'(icy) - DB'(signed'({1'b0, radius_reg}));
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            cx0_reg <= DB'(icx);
            cy0_reg <= cyn;
            dx0_reg <= DB'(ifx) - DB'(icx);
            dy0_reg <= DB'(ify) - cyn;
            r0_reg  <= radius_reg;
        end
    end

    // Stage 1: squares (coordinate range keeps offsets under 2^25, no scaling).
    logic [MB-1:0] d2_1_reg;
    logic [SQW-1:0] rad1;
    logic signed [DB-1:0] cx1_reg, cy1_reg, dx1_reg, dy1_reg;
    logic [RADIUS_WIDTH-1:0] r1_reg;
    logic inside1_reg;
    logic [DB-1:0] adx, ady;
    logic [MB-1:0] d2c, r2c;
    always_comb begin
        adx = dx0_reg[DB-1] ? DB'(-dx0_reg) : DB'(dx0_reg);
        ady = dy0_reg[DB-1] ? DB'(-dy0_reg) : DB'(dy0_reg);
        d2c = MB'(adx) * MB'(adx) + MB'(ady) * MB'(ady);
        r2c = MB'(r0_reg) * MB'(r0_reg);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_1_reg    <= d2c;
            inside1_reg <= d2c <= r2c;
            cx1_reg <= cx0_reg; cy1_reg <= cy0_reg;
            dx1_reg <= dx0_reg; dy1_reg <= dy0_reg;
            r1_reg  <= r0_reg;
        end
    end
    assign rad1 = SQW'(d2_1_reg - MB'(r1_reg) * MB'(r1_reg));

    // Square-root pipeline, one root bit per stage.
    logic [SQW-1:0] sq_rem_reg [NSQ+1];
    logic [SQW-1:0] sq_src_reg [NSQ+1];
    logic [SB-1:0]  sq_root_reg [NSQ+1];
    logic [MB-1:0]  sq_d2_reg [NSQ+1];
    logic signed [DB-1:0] sq_cx_reg [NSQ+1], sq_cy_reg [NSQ+1];
    logic signed [DB-1:0] sq_dx_reg [NSQ+1], sq_dy_reg [NSQ+1];
    logic [RADIUS_WIDTH-1:0] sq_r_reg [NSQ+1];
    logic sq_in_reg [NSQ+1];
    always_comb begin
        sq_rem_reg[0]  = '0;
        sq_src_reg[0]  = rad1;
        sq_root_reg[0] = '0;
        sq_d2_reg[0]   = d2_1_reg;
        sq_cx_reg[0] = cx1_reg; sq_cy_reg[0] = cy1_reg;
        sq_dx_reg[0] = dx1_reg; sq_dy_reg[0] = dy1_reg;
        sq_r_reg[0]  = r1_reg;  sq_in_reg[0] = inside1_reg;
    end
    for (genvar i = 0; i < NSQ; i++) begin : g_sq
        logic [SQW-1:0] rem_n;
        logic [SB-1:0]  root_n;
        ctp_isqrt_stage #(.W(SQW)) u_step (
            .rem_in  (sq_rem_reg[i]),
            .root_in (sq_root_reg[i]),
            .pair_in (sq_src_reg[i][SQW-1 -: 2]),
            .rem_out (rem_n),
            .root_out(root_n)
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[i+1]  <= rem_n;
                sq_root_reg[i+1] <= root_n;
                sq_src_reg[i+1]  <= {sq_src_reg[i][SQW-3:0], 2'b00};
                sq_d2_reg[i+1]   <= sq_d2_reg[i];
                sq_cx_reg[i+1] <= sq_cx_reg[i]; sq_cy_reg[i+1] <= sq_cy_reg[i];
                sq_dx_reg[i+1] <= sq_dx_reg[i]; sq_dy_reg[i+1] <= sq_dy_reg[i];
                sq_r_reg[i+1]  <= sq_r_reg[i];  sq_in_reg[i+1] <= sq_in_reg[i];
            end
        end
    end

    // Numerator stage: four signed numerators.
    localparam int SNB = NB + 1;
    logic signed [SNB-1:0] num_reg [4];
    logic [MB-1:0] nd2_reg;
    logic signed [DB-1:0] ncx_reg, ncy_reg, ndx_reg, ndy_reg;
    logic [RADIUS_WIDTH-1:0] nr_reg;
    logic nin_reg;
    logic signed [SNB-1:0] rdx, rdy, sdx, sdy;
    always_comb begin
        rdx = SNB'(signed'({1'b0, sq_r_reg[NSQ]})) * SNB'(sq_dx_reg[NSQ]);
        rdy = SNB'(signed'({1'b0, sq_r_reg[NSQ]})) * SNB'(sq_dy_reg[NSQ]);
        sdx = SNB'(signed'({1'b0, sq_root_reg[NSQ]})) * SNB'(sq_dx_reg[NSQ]);
        sdy = SNB'(signed'({1'b0, sq_root_reg[NSQ]})) * SNB'(sq_dy_reg[NSQ]);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg[0] <= rdx - sdy;
            num_reg[1] <= rdy + sdx;
            num_reg[2] <= rdx + sdy;
            num_reg[3] <= rdy - sdx;
            nd2_reg <= sq_d2_reg[NSQ];
            ncx_reg <= sq_cx_reg[NSQ]; ncy_reg <= sq_cy_reg[NSQ];
            ndx_reg <= sq_dx_reg[NSQ]; ndy_reg <= sq_dy_reg[NSQ];
            nr_reg  <= sq_r_reg[NSQ];  nin_reg <= sq_in_reg[NSQ];
        end
    end

    // Ratio divider: four lanes, one quotient bit per stage (first bit is
    // the integer part, since |N| <= d2).
    logic [DW-1:0] dv_rem_reg [NDV+1][4];
    logic [QB-1:0] dv_q_reg [NDV+1][4];
    logic [3:0]    dv_neg_reg [NDV+1];
    logic [DW-1:0] dv_den_reg [NDV+1];
    logic signed [DB-1:0] dv_cx_reg [NDV+1], dv_cy_reg [NDV+1];
    logic signed [DB-1:0] dv_dx_reg [NDV+1], dv_dy_reg [NDV+1];
    logic [RADIUS_WIDTH-1:0] dv_r_reg [NDV+1];
    logic dv_in_reg [NDV+1];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            // The first step uses the full magnitude, so it yields the integer bit.
            dv_rem_reg[0][k] = '0;
            dv_q_reg[0][k]   = '0;
            dv_neg_reg[0][k] = num_reg[k][SNB-1];
        end
        dv_den_reg[0] = DW'(nd2_reg);
        dv_cx_reg[0] = ncx_reg; dv_cy_reg[0] = ncy_reg;
        dv_dx_reg[0] = ndx_reg; dv_dy_reg[0] = ndy_reg;
        dv_r_reg[0]  = nr_reg;  dv_in_reg[0] = nin_reg;
    end
    logic [DW-1:0] mag0 [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag0[k] = num_reg[k][SNB-1] ? DW'(-num_reg[k]) : DW'(num_reg[k]);
        end
    end
    for (genvar i = 0; i < NDV; i++) begin : g_dv
        for (genvar k = 0; k < 4; k++) begin : g_lane
            logic [DW-1:0] rem_n;
            logic [DW-1:0] rem_src;
            logic          qb;
            // First step compares the magnitude itself against d2.
            assign rem_src = (i == 0) ? (mag0[k] >> 1) : dv_rem_reg[i][k];
            ctp_div_stage #(.W(DW)) u_step (
                .rem_in (i == 0 ? rem_src : dv_rem_reg[i][k]),
                .den    (dv_den_reg[i]),
                .rem_out(rem_n),
                .q_bit  (qb)
            );
            logic [DW-1:0] rem_fix;
            logic          q_fix;
            // Odd low bit lost by the halving is restored in the first step.
            always_comb begin
                if (i == 0) begin
                    q_fix   = mag0[k] >= dv_den_reg[i];
                    rem_fix = q_fix ? mag0[k] - dv_den_reg[i] : mag0[k];
                end else begin
                    q_fix   = qb;
                    rem_fix = rem_n;
                end
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dv_rem_reg[i+1][k] <= rem_fix;
                    dv_q_reg[i+1][k]   <= {dv_q_reg[i][k][QB-2:0], q_fix};
                    dv_neg_reg[i+1][k] <= dv_neg_reg[i][k];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_den_reg[i+1] <= dv_den_reg[i];
                dv_cx_reg[i+1] <= dv_cx_reg[i]; dv_cy_reg[i+1] <= dv_cy_reg[i];
                dv_dx_reg[i+1] <= dv_dx_reg[i]; dv_dy_reg[i+1] <= dv_dy_reg[i];
                dv_r_reg[i+1]  <= dv_r_reg[i];  dv_in_reg[i+1] <= dv_in_reg[i];
            end
        end
    end

    // Scale stage: r * q, rounded, sign restored.
    localparam int PB = RADIUS_WIDTH + 1;
    logic signed [PB:0] p_reg [4];
    logic signed [DB-1:0] pcx_reg, pcy_reg, pdx_reg, pdy_reg;
    logic pin_reg;
    logic [RADIUS_WIDTH+QB-1:0] prod [4];
    logic [PB-1:0] pm [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = (RADIUS_WIDTH+QB)'(dv_r_reg[NDV]) * (RADIUS_WIDTH+QB)'(dv_q_reg[NDV][k])
                    + (RADIUS_WIDTH+QB)'(1) * (RADIUS_WIDTH+QB)'(2**(RATIO_BITS-1));
            pm[k]   = PB'(prod[k] >> RATIO_BITS);
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                p_reg[k] <= dv_neg_reg[NDV][k] ? -signed'({1'b0, pm[k]})
                                               :  signed'({1'b0, pm[k]});
            end
            pcx_reg <= dv_cx_reg[NDV]; pcy_reg <= dv_cy_reg[NDV];
            pdx_reg <= dv_dx_reg[NDV]; pdy_reg <= dv_dy_reg[NDV];
            pin_reg <= dv_in_reg[NDV];
        end
    end

    // Compare stage: cross products of the slope terms.
    localparam int EB = DB + 2;
    logic signed [EB-1:0] e1, n1, e2, n2;
    logic [EB-1:0] ae1, an1, ae2, an2;
    logic pick1_reg;
    logic signed [PB:0] c1x_reg, c1y_reg, c2x_reg, c2y_reg;
    logic signed [DB-1:0] ccx_reg, ccy_reg;
    logic cin_reg;
    always_comb begin
        e1 = EB'(pdx_reg) - EB'(p_reg[0]);
        n1 = EB'(pdy_reg) - EB'(p_reg[1]);
        e2 = EB'(pdx_reg) - EB'(p_reg[2]);
        n2 = EB'(pdy_reg) - EB'(p_reg[3]);
        ae1 = e1[EB-1] ? EB'(-e1) : EB'(e1);
        an1 = n1[EB-1] ? EB'(-n1) : EB'(n1);
        ae2 = e2[EB-1] ? EB'(-e2) : EB'(e2);
        an2 = n2[EB-1] ? EB'(-n2) : EB'(n2);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            pick1_reg <= (2*EB)'(an1) * (2*EB)'(ae2) < (2*EB)'(an2) * (2*EB)'(ae1);
            c1x_reg <= p_reg[0]; c1y_reg <= p_reg[1];
            c2x_reg <= p_reg[2]; c2y_reg <= p_reg[3];
            ccx_reg <= pcx_reg; ccy_reg <= pcy_reg;
            cin_reg <= pin_reg;
        end
    end

    // Output stage: add centre, saturate, zero when inside.
    localparam int SUMB = DB + 2;
    logic signed [SUMB-1:0] sx, sy;
    logic signed [CB-1:0] tx_reg, ty_reg;
    logic in_reg;
    function automatic logic signed [CB-1:0] sat(input logic signed [SUMB-1:0] v);
        logic signed [SUMB-1:0] hi, lo;
        hi = SUMB'((64'sd1 <<< (CB-1)) - 1);
        lo = -SUMB'(64'sd1 <<< (CB-1));
        if (v > hi)      sat = CB'(hi);
        else if (v < lo) sat = CB'(lo);
        else             sat = CB'(v);
    endfunction
    always_comb begin
        sx = SUMB'(ccx_reg) + SUMB'(pick1_reg ? c1x_reg : c2x_reg);
        sy = SUMB'(ccy_reg) + SUMB'(pick1_reg ? c1y_reg : c2y_reg);
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg <= cin_reg ? '0 : sat(sx);
            ty_reg <= cin_reg ? '0 : sat(sy);
            in_reg <= cin_reg;
        end
    end

    assign m_axis_tvalid = v_reg[DEPTH-1];
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, ty_reg, tx_reg};
    assign m_axis_tuser  = in_reg;

    // Assertions
    `CTP_ASSERT_IMPL(a_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result lost under stall")
    `CTP_ASSERT_IMPL(a_zero, aclk, aresetn, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "inside result not zero")
    `CTP_ASSERT_RESET(a_rst, aclk, aresetn, !aresetn |=> !m_axis_tvalid, "valid after reset")
endmodule
